>>> rtl/core/ctrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctrr_pkg
// Types and constants shared by the calendar time to RTC register encoder.
// ----------------------------------------------------------------------------
package ctrr_pkg;

    // one calendar time, as it enters the block
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
    } t_in_item;

    // the seven RTC register bytes, at their field widths
    typedef struct packed {
        logic [6:0] seconds_bcd;
        logic [6:0] minutes_bcd;
        logic [5:0] hours_bcd;
        logic [2:0] weekday_code;
        logic [5:0] date_bcd;
        logic [4:0] month_bcd;
        logic [7:0] year_bcd;
    } t_out_item;

    // year offset base
    localparam logic [11:0] YEAR_BASE = 12'd2000;

    // last month that counts towards the previous year in the shifted calendar
    localparam logic [3:0] MONTH_FEB = 4'd2;

    // reciprocal multipliers for constant division
    localparam logic [7:0]  DIV10_MUL_SMALL = 8'd205;    // v/10 = (v*205)>>11, v < 64
    localparam logic [12:0] DIV10_MUL_WIDE  = 13'd6554;  // v/10 = (v*6554)>>16, v < 4096
    localparam logic [12:0] DIV100_MUL      = 13'd5243;  // v/100 = (v*5243)>>19, v < 4096
    localparam logic [13:0] DIV7_MUL        = 14'd9363;  // v/7 = (v*9363)>>16, v < 8192

endpackage
`default_nettype wire

>>> rtl/core/ctrr_bcd2.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctrr_bcd2
// Splits a value below 64 into its tens and ones decimal digits.
// ----------------------------------------------------------------------------
module ctrr_bcd2 (
    input  wire logic [5:0] i_value,
    output logic      [2:0] o_tens,
    output logic      [3:0] o_ones
);

    logic [13:0] w_prod;
    logic [5:0]  w_rem;

    // tens by reciprocal multiply, ones as the remainder
    assign w_prod = i_value * ctrr_pkg::DIV10_MUL_SMALL;
    assign o_tens = w_prod[13:11];
    assign w_rem  = i_value - (6'({o_tens, 3'b000}) + 6'({o_tens, 1'b0}));
    assign o_ones = w_rem[3:0];

endmodule
`default_nettype wire

>>> rtl/core/calendar_time_to_rtc_registers_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_time_to_rtc_registers_unit
// Encodes a calendar time into seven RTC register bytes in packed BCD (the year
// byte only for years 2000 to 2099), including the Gregorian day of week (Sunday is 1).
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+---------------------------
//  input    | i_in_valid   | o_in_stall   | i_in_item  (t_in_item)
//  output   | o_out_valid  | i_out_stall  | o_out_item (t_out_item)
//
//  Five register stages; one transfer per cycle sustained while the output is not stalled.
//  The stages are set by the multiplier chain: divide by 100 and 10, then
//  the weekday sum, then divide by 7, then the remainder.
//  Reset clears the stage valid bits only.
//  Each stage holds while the one after it is full and held; a bubble is
//  filled even while the output is stalled.
// ----------------------------------------------------------------------------
module calendar_time_to_rtc_registers_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire ctrr_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output ctrr_pkg::t_out_item       o_out_item
);

    // stage valid bits and load enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    assign w_rdy5     = !r_v5 || !i_out_stall;
    assign w_rdy4     = !r_v4 || w_rdy5;
    assign w_rdy3     = !r_v3 || w_rdy4;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_stall = !w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: small BCD fields, shifted month term, shifted year
    // ------------------------------------------------------------------
    logic [2:0] w_sec_t, w_min_t, w_hr_t, w_day_t, w_mon_t;
    logic [3:0] w_sec_o, w_min_o, w_hr_o, w_day_o, w_mon_o;
    logic       w_early;
    logic [5:0] w_mterm;
    ctrr_pkg::t_out_item w_o1;

    ctrr_bcd2 u_bcd_sec (.i_value(i_in_item.seconds),      .o_tens(w_sec_t), .o_ones(w_sec_o));
    ctrr_bcd2 u_bcd_min (.i_value(i_in_item.minutes),      .o_tens(w_min_t), .o_ones(w_min_o));
    ctrr_bcd2 u_bcd_hr  (.i_value({1'b0, i_in_item.hours}), .o_tens(w_hr_t), .o_ones(w_hr_o));
    ctrr_bcd2 u_bcd_day (.i_value({1'b0, i_in_item.day}),   .o_tens(w_day_t), .o_ones(w_day_o));
    ctrr_bcd2 u_bcd_mon (.i_value({2'b00, i_in_item.month}), .o_tens(w_mon_t), .o_ones(w_mon_o));

    always_comb begin
        w_o1              = '0;
        w_o1.seconds_bcd  = {w_sec_t, w_sec_o};
        w_o1.minutes_bcd  = {w_min_t, w_min_o};
        w_o1.hours_bcd    = {w_hr_t[1:0], w_hr_o};
        w_o1.date_bcd     = {w_day_t[1:0], w_day_o};
        w_o1.month_bcd    = {w_mon_t[0], w_mon_o};
    end

    assign w_early = (i_in_item.month <= ctrr_pkg::MONTH_FEB);

    // (13*m - 1)/5 for the March-based month
    always_comb begin
        case (i_in_item.month)
            4'd0:    w_mterm = 6'd25;
            4'd1:    w_mterm = 6'd28;
            4'd2:    w_mterm = 6'd31;
            4'd3:    w_mterm = 6'd2;
            4'd4:    w_mterm = 6'd5;
            4'd5:    w_mterm = 6'd7;
            4'd6:    w_mterm = 6'd10;
            4'd7:    w_mterm = 6'd12;
            4'd8:    w_mterm = 6'd15;
            4'd9:    w_mterm = 6'd18;
            4'd10:   w_mterm = 6'd20;
            4'd11:   w_mterm = 6'd23;
            4'd12:   w_mterm = 6'd25;
            4'd13:   w_mterm = 6'd28;
            4'd14:   w_mterm = 6'd31;
            4'd15:   w_mterm = 6'd33;
            default: w_mterm = 6'd0;
        endcase
    end

    ctrr_pkg::t_out_item r_s1_o;
    logic [4:0]  r_s1_day;
    logic [5:0]  r_s1_mterm;
    logic [11:0] r_s1_yy;
    logic        r_s1_yneg;
    logic        r_s1_ylow;
    logic [11:0] r_s1_yd;

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_o     <= w_o1;
            r_s1_day   <= i_in_item.day;
            r_s1_mterm <= w_mterm;
            r_s1_yy    <= i_in_item.year - {11'd0, w_early};
            r_s1_yneg  <= w_early && (i_in_item.year == 12'd0);
            r_s1_ylow  <= (i_in_item.year < ctrr_pkg::YEAR_BASE);
            r_s1_yd    <= i_in_item.year - ctrr_pkg::YEAR_BASE;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: year / 100 and year offset / 10
    // ------------------------------------------------------------------
    logic [24:0] w_p100;
    logic [24:0] w_p10;

    assign w_p100 = r_s1_yy * ctrr_pkg::DIV100_MUL;
    assign w_p10  = r_s1_yd * ctrr_pkg::DIV10_MUL_WIDE;

    ctrr_pkg::t_out_item r_s2_o;
    logic [4:0]  r_s2_day;
    logic [5:0]  r_s2_mterm;
    logic [11:0] r_s2_yy;
    logic        r_s2_yneg;
    logic        r_s2_ylow;
    logic [11:0] r_s2_yd;
    logic [5:0]  r_s2_q100;
    logic [7:0]  r_s2_q10;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_o     <= r_s1_o;
            r_s2_day   <= r_s1_day;
            r_s2_mterm <= r_s1_mterm;
            r_s2_yy    <= r_s1_yy;
            r_s2_yneg  <= r_s1_yneg;
            r_s2_ylow  <= r_s1_ylow;
            r_s2_yd    <= r_s1_yd;
            r_s2_q100  <= w_p100[24:19];
            r_s2_q10   <= w_p10[23:16];
        end
    end

    // ------------------------------------------------------------------
    // stage 3: weekday sum and year byte
    // ------------------------------------------------------------------
    logic [11:0] w_yrem;
    logic [12:0] w_sum;
    ctrr_pkg::t_out_item w_o3;

    assign w_yrem = r_s2_yd - (12'({r_s2_q10, 3'b000}) + 12'({r_s2_q10, 1'b0}));

    always_comb begin
        w_o3 = r_s2_o;
        // below the base year the byte is the plain two's complement offset
        w_o3.year_bcd = r_s2_ylow ? r_s2_yd[7:0] : {r_s2_q10[3:0], w_yrem[3:0]};
    end

    // shifted year of -1 divides to zero in every term
    always_comb begin
        if (r_s2_yneg) begin
            w_sum = 13'(r_s2_day) + 13'(r_s2_mterm) - 13'd1;
        end else begin
            w_sum = 13'(r_s2_day) + 13'(r_s2_mterm) + 13'(r_s2_yy) + 13'(r_s2_yy[11:2])
                  - 13'(r_s2_q100) + 13'(r_s2_q100[5:2]);
        end
    end

    ctrr_pkg::t_out_item r_s3_o;
    logic [12:0] r_s3_sum;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3_o   <= w_o3;
            r_s3_sum <= w_sum;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: sum / 7
    // ------------------------------------------------------------------
    logic [26:0] w_p7;

    assign w_p7 = r_s3_sum * ctrr_pkg::DIV7_MUL;

    ctrr_pkg::t_out_item r_s4_o;
    logic [12:0] r_s4_sum;
    logic [9:0]  r_s4_q7;

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_s4_o   <= r_s3_o;
            r_s4_sum <= r_s3_sum;
            r_s4_q7  <= w_p7[25:16];
        end
    end

    // ------------------------------------------------------------------
    // stage 5: remainder mod 7, weekday code, output register
    // ------------------------------------------------------------------
    logic [12:0] w_r7;
    ctrr_pkg::t_out_item w_o5;

    assign w_r7 = r_s4_sum - (13'({r_s4_q7, 3'b000}) - 13'(r_s4_q7));

    always_comb begin
        w_o5 = r_s4_o;
        w_o5.weekday_code = w_r7[2:0] + 3'd1;
    end

    ctrr_pkg::t_out_item r_s5_o;

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r_s5_o <= w_o5;
        end
    end

    assign o_out_valid = r_v5;
    assign o_out_item  = r_s5_o;

endmodule
`default_nettype wire

>>> test/ctrr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctrr_checker
// Watches both channels of the RTC register encoder. It predicts the seven
// register bytes of every calendar time that goes in, keeps them in order,
// and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module ctrr_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  wire ctrr_pkg::t_in_item  i_in_item,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire ctrr_pkg::t_out_item i_out_item,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_result_count
);

    // register sets predicted but not yet seen on the output
    ctrr_pkg::t_out_item expected_regs[$];
    ctrr_pkg::t_out_item want;
    int                  fail_cnt;
    int                  result_cnt;

    // two decimal digits, tens in the upper nibble, no range limit on tens
    function automatic logic [31:0] pack_bcd(input logic [31:0] v);
        logic [31:0] tens;
        logic [31:0] ones;
        tens = v / 32'd10;
        ones = v % 32'd10;
        return (tens << 4) | ones;
    endfunction

    // Gregorian weekday plus one, Sunday is 1; March-based shifted months
    function automatic logic [2:0] weekday_code_of(input logic [11:0] year,
                                                   input logic [3:0]  month,
                                                   input logic [4:0]  day);
        int m;
        int y;
        int d;
        int early;
        int mm;
        int yy;
        int total;
        int r;
        m = month;
        y = year;
        d = day;
        // January, February and month zero belong to the previous year
        early = (m <= 2) ? 1 : 0;
        mm = m + 12 * early - 2;
        yy = y - early;
        // divisions truncate towards zero, so year -1 gives 0 for each
        total = d + (13 * mm - 1) / 5 + yy + yy / 4 - yy / 100 + yy / 400;
        r = total % 7;
        if (r < 0) begin
            r += 7;
        end
        return 3'(r + 1);
    endfunction

    function automatic ctrr_pkg::t_out_item encode_rtc_regs(input ctrr_pkg::t_in_item t);
        ctrr_pkg::t_out_item r;
        logic [31:0]         yoff;
        r.seconds_bcd  = 7'(pack_bcd({26'd0, t.seconds}));
        r.minutes_bcd  = 7'(pack_bcd({26'd0, t.minutes}));
        r.hours_bcd    = 6'(pack_bcd({27'd0, t.hours}));
        r.weekday_code = weekday_code_of(t.year, t.month, t.day);
        r.date_bcd     = 6'(pack_bcd({27'd0, t.day}));
        r.month_bcd    = 5'(pack_bcd({28'd0, t.month}));
        // below the base year the raw two's complement difference is kept
        yoff = {20'd0, t.year} - {20'd0, ctrr_pkg::YEAR_BASE};
        if (t.year < ctrr_pkg::YEAR_BASE) begin
            r.year_bcd = yoff[7:0];
        end else begin
            r.year_bcd = 8'(pack_bcd(yoff));
        end
        return r;
    endfunction

    task automatic check_field(input string field, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", field, exp_val, act_val);
            fail_cnt++;
        end
    endtask

    // queue on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_regs.delete();
            fail_cnt   = 0;
            result_cnt = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_regs.push_back(encode_rtc_regs(i_in_item));
            end
            if (i_out_valid && !i_out_stall) begin
                result_cnt++;
                if (expected_regs.size() == 0) begin
                    $error("output transfer with no calendar time outstanding");
                    fail_cnt++;
                end else begin
                    want = expected_regs.pop_front();
                    check_field("seconds_bcd", want.seconds_bcd, i_out_item.seconds_bcd);
                    check_field("minutes_bcd", want.minutes_bcd, i_out_item.minutes_bcd);
                    check_field("hours_bcd", want.hours_bcd, i_out_item.hours_bcd);
                    check_field("weekday_code", want.weekday_code, i_out_item.weekday_code);
                    check_field("date_bcd", want.date_bcd, i_out_item.date_bcd);
                    check_field("month_bcd", want.month_bcd, i_out_item.month_bcd);
                    check_field("year_bcd", want.year_bcd, i_out_item.year_bcd);
                end
            end
        end
        o_fail_count   <= fail_cnt;
        o_pending      <= expected_regs.size();
        o_result_count <= result_cnt;
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives calendar times into the RTC register encoder: a set of edge cases,
// then random times, mostly well formed with some raw field values. The
// sender runs in bursts and the receiver stalls in changing patterns; the
// checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_EDGE      = 22;
    localparam int N_RANDOM    = 1428;
    localparam int MID_DRAIN   = 700;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 20;

    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_BLOCKS,
        RX_TOGGLE
    } t_stall_pattern;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    ctrr_pkg::t_in_item  in_item   = '0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    ctrr_pkg::t_out_item out_item;

    int fail_count;
    int pending;
    int result_count;
    int cycles     = 0;
    int burst_left = 0;
    int sent       = 0;

    t_stall_pattern stall_mode = RX_FREE;
    int             mode_left  = 0;
    int             phase      = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    calendar_time_to_rtc_registers_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    ctrr_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_item      (in_item),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_item     (out_item),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // run guard
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver back-pressure: the pattern is picked at random and changes when its random run length ends
    always @(posedge clk) begin
        if (mode_left == 0) begin
            stall_mode = t_stall_pattern'($urandom_range(3, 0));
            mode_left  = $urandom_range(200, 20);
        end
        mode_left--;
        phase++;
        case (stall_mode)
            RX_FREE:   out_stall <= 1'b0;
            RX_RANDOM: out_stall <= ($urandom_range(99, 0) < 35);
            RX_BLOCKS: out_stall <= ((phase % 12) < 8);
            default:   out_stall <= phase[0];
        endcase
    end

    // one input transfer; a new burst mostly starts with a random gap
    task automatic send_time(input ctrr_pkg::t_in_item t);
        if (burst_left == 0) begin
            if ($urandom_range(3, 0) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(8, 1)) @(posedge clk);
            end
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(150, 60)
                                                      : $urandom_range(16, 1);
        end
        in_valid <= 1'b1;
        in_item  <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        sent++;
    endtask

    // hold the sender off until every outstanding result is out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        burst_left = 0;
    endtask

    initial begin
        ctrr_pkg::t_in_item t;
        int                 k;
        int                 mlen;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edge cases: field extremes, leap days, century rules, odd months
        for (k = 0; k < N_EDGE; k++) begin
            case (k)
                0:  t = '{12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0};
                1:  t = '{12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59};
                2:  t = '{12'd2000, 4'd2, 5'd29, 5'd12, 6'd34, 6'd56};
                3:  t = '{12'd2100, 4'd3, 5'd1, 5'd1, 6'd2, 6'd3};
                4:  t = '{12'd2024, 4'd2, 5'd29, 5'd6, 6'd30, 6'd0};
                5:  t = '{12'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59};
                6:  t = '{12'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd1};
                7:  t = '{12'd0, 4'd2, 5'd15, 5'd4, 6'd5, 6'd6};
                8:  t = '{12'd0, 4'd0, 5'd10, 5'd7, 6'd8, 6'd9};
                9:  t = '{12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63};
                10: t = '{12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0};
                11: t = '{12'd2050, 4'd13, 5'd5, 5'd18, 6'd20, 6'd40};
                12: t = '{12'd2010, 4'd3, 5'd1, 5'd8, 6'd15, 6'd45};
                13: t = '{12'd2077, 4'd7, 5'd4, 5'd24, 6'd60, 6'd60};
                14: t = '{12'd2000, 4'd6, 5'd15, 5'd9, 6'd9, 6'd9};
                15: t = '{12'd2099, 4'd2, 5'd28, 5'd20, 6'd10, 6'd19};
                16: t = '{12'd2100, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0};
                17: t = '{12'd2087, 4'd10, 5'd31, 5'd10, 6'd10, 6'd10};
                18: t = '{12'd2001, 4'd11, 5'd30, 5'd19, 6'd45, 6'd30};
                19: t = '{12'd4000, 4'd2, 5'd29, 5'd11, 6'd11, 6'd11};
                20: t = '{12'd1900, 4'd3, 5'd1, 5'd22, 6'd22, 6'd22};
                default: t = '{12'd2045, 4'd12, 5'd0, 5'd16, 6'd1, 6'd2};
            endcase
            send_time(t);
        end
        drain_results();

        // random times: most within the calendar, some raw field values
        for (k = 0; k < N_RANDOM; k++) begin
            if ($urandom_range(99, 0) < 15) begin
                t.year    = 12'($urandom_range(4095, 0));
                t.month   = 4'($urandom_range(15, 0));
                t.day     = 5'($urandom_range(31, 0));
                t.hours   = 5'($urandom_range(31, 0));
                t.minutes = 6'($urandom_range(63, 0));
                t.seconds = 6'($urandom_range(63, 0));
            end else begin
                t.year  = 12'($urandom_range(2099, 2000));
                t.month = 4'($urandom_range(12, 1));
                case (t.month)
                    4'd2:                      mlen = (t.year % 4 == 0) ? 29 : 28;
                    4'd4, 4'd6, 4'd9, 4'd11:   mlen = 30;
                    default:                   mlen = 31;
                endcase
                t.day     = 5'($urandom_range(mlen, 1));
                t.hours   = 5'($urandom_range(23, 0));
                t.minutes = 6'($urandom_range(59, 0));
                t.seconds = 6'($urandom_range(59, 0));
            end
            send_time(t);
            if (k == MID_DRAIN) begin
                drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pending != 0) begin
            $error("%0d register sets still outstanding at the end", pending);
        end
        $display("Run covered %0d calendar times: %0d edge cases, the rest random,",
                 sent, N_EDGE);
        $display("about one in seven raw; %0d results checked under bursty input and stalls.",
                 result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/ctrr_pkg.sv
rtl/core/ctrr_bcd2.sv
rtl/core/calendar_time_to_rtc_registers_unit.sv
test/ctrr_checker.sv
test/tb_top.sv
